@@ rtl/bn12_pkg.sv @@
// shared types, constants and helpers for the bgra to nv12 converter
`default_nettype none

package bn12_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int LINE_IDX_W = $clog2(LINE_DEPTH);
	localparam int POS_W = 12;
	localparam int CFG_W = 13;
	localparam int SUM_W = 9;
	localparam int LINE_W = 3 * SUM_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd1920;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd1080;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STEP_Y = 2'd0,
		STEP_U = 2'd1,
		STEP_V = 2'd2
	} step_t;

	// one pixel after the front end: luma done, chroma as channel averages
	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] column;
		logic [7:0]       luma;
		logic             chroma;
		logic             edge_pair;
		logic [7:0]       avg_b;
		logic [7:0]       avg_g;
		logic [7:0]       avg_r;
	} quad_entry_t;

	function automatic logic [7:0] clamp_byte(input logic signed [16:0] v);
		logic [7:0] res;
		if (v < 17'sd0) begin
			res = 8'd0;
		end else if (v > 17'sd255) begin
			res = 8'd255;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

@@ rtl/bn12_queue.sv @@
// short word queue between the front end and the result sequencer
`default_nettype none

module bn12_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push_valid,
	output logic                       push_ready,
	input  wire bn12_pkg::quad_entry_t push_entry,
	output logic                       pop_valid,
	input  wire logic                  pop_ready,
	output bn12_pkg::quad_entry_t      pop_entry
);

	bn12_pkg::quad_entry_t               slot_q [bn12_pkg::QUEUE_DEPTH];
	logic [bn12_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [bn12_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [bn12_pkg::QUEUE_PTR_W:0]     count_q;
	logic                               push;
	logic                               pop;

	assign push_ready = (count_q != (bn12_pkg::QUEUE_PTR_W+1)'(bn12_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_entry = slot_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/bn12_front.sv @@
// front end: pixel intake, raster position, luma, pair sums and the chroma line store
`default_nettype none

module bn12_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [bn12_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [23:0]                  s_tdata,
	output logic                              push_valid,
	input  wire logic                         push_ready,
	output bn12_pkg::quad_entry_t             push_entry
);

	localparam int PW = bn12_pkg::POS_W;
	localparam int CW = bn12_pkg::CFG_W;
	localparam int SW = bn12_pkg::SUM_W;

	// configuration and raster state
	logic [CW-1:0] frame_width_q;
	logic [CW-1:0] frame_height_q;
	logic [PW-1:0] col_q;
	logic [PW-1:0] row_q;
	logic [23:0]   left_q;

	// chroma line store, one word per column pair of the even row
	logic [bn12_pkg::LINE_W-1:0] line_mem [bn12_pkg::LINE_DEPTH];
	logic [bn12_pkg::LINE_W-1:0] line_rd_s1;

	// stage 1
	logic          s1_valid_q;
	logic [PW-1:0] x_s1;
	logic [PW-1:0] y_s1;
	logic [7:0]    b_s1;
	logic [7:0]    g_s1;
	logic [7:0]    r_s1;
	logic [SW-1:0] sb_s1;
	logic [SW-1:0] sg_s1;
	logic [SW-1:0] sr_s1;
	logic          odd_s1;
	logic          emit_s1;
	logic          edge_s1;

	logic [CW-1:0] w_sat;
	logic [CW-1:0] h_sat;
	logic          col_wrap;
	logic [CW-1:0] row_t;
	logic [PW-1:0] x;
	logic [PW-1:0] y;
	logic [CW-1:0] x_next;
	logic [CW-1:0] y_next;
	logic          edge_pair;
	logic          pair_done;
	logic          last_row;
	logic [7:0]    pix_b;
	logic [7:0]    pix_g;
	logic [7:0]    pix_r;
	logic [SW-1:0] sum_b;
	logic [SW-1:0] sum_g;
	logic [SW-1:0] sum_r;
	logic          accept;
	logic          line_wr;
	logic [bn12_pkg::LINE_IDX_W-1:0] line_idx;

	logic [SW:0]   quad_b;
	logic [SW:0]   quad_g;
	logic [SW:0]   quad_r;
	logic [SW:0]   quad_b_rnd;
	logic [SW:0]   quad_g_rnd;
	logic [SW:0]   quad_r_rnd;
	logic [15:0]   luma_sum;

	assign pix_b = s_tdata[7:0];
	assign pix_g = s_tdata[15:8];
	assign pix_r = s_tdata[23:16];

	// out-of-range sizes saturate, zero acts as one
	always_comb begin
		if (frame_width_q == '0) begin
			w_sat = CW'(1);
		end else if (frame_width_q > CW'(bn12_pkg::MAX_WIDTH)) begin
			w_sat = CW'(bn12_pkg::MAX_WIDTH);
		end else begin
			w_sat = frame_width_q;
		end
		if (frame_height_q == '0) begin
			h_sat = CW'(1);
		end else if (frame_height_q > CW'(bn12_pkg::MAX_HEIGHT)) begin
			h_sat = CW'(bn12_pkg::MAX_HEIGHT);
		end else begin
			h_sat = frame_height_q;
		end
	end

	// position of this pixel, rewrapped in case the size shrank
	always_comb begin
		col_wrap = ({1'b0, col_q} >= w_sat);
		row_t = {1'b0, row_q} + (col_wrap ? CW'(1) : CW'(0));
		x = col_wrap ? '0 : col_q;
		y = (row_t >= h_sat) ? '0 : row_t[PW-1:0];
		x_next = {1'b0, x} + CW'(1);
		y_next = {1'b0, y} + CW'(1);
		edge_pair = !x[0] && (x_next == w_sat);
		pair_done = x[0] || edge_pair;
		last_row = (y_next == h_sat);
		line_idx = x[bn12_pkg::LINE_IDX_W:1];
	end

	// horizontal pair sums, edge pixel counted twice
	always_comb begin
		if (edge_pair) begin
			sum_b = {pix_b, 1'b0};
			sum_g = {pix_g, 1'b0};
			sum_r = {pix_r, 1'b0};
		end else begin
			sum_b = {1'b0, left_q[7:0]} + {1'b0, pix_b};
			sum_g = {1'b0, left_q[15:8]} + {1'b0, pix_g};
			sum_r = {1'b0, left_q[23:16]} + {1'b0, pix_r};
		end
	end

	assign s_tready = !s1_valid_q || push_ready;
	assign accept = s_tvalid && s_tready;
	assign line_wr = accept && pair_done && !y[0] && !last_row;

	always_ff @(posedge clk) begin
		if (line_wr) begin
			line_mem[line_idx] <= {sum_r, sum_g, sum_b};
		end
		if (accept) begin
			line_rd_s1 <= line_mem[line_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= bn12_pkg::WIDTH_RESET;
			frame_height_q <= bn12_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (bn12_pkg::cfg_reg_t'(cfg_index))
				bn12_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data;
				end
				bn12_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data;
				end
				default: begin
					frame_width_q <= frame_width_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			left_q <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (!x[0]) begin
					left_q <= s_tdata;
				end
				if (x_next >= w_sat) begin
					col_q <= '0;
					row_q <= (y_next >= h_sat) ? '0 : y_next[PW-1:0];
				end else begin
					col_q <= x_next[PW-1:0];
					row_q <= y;
				end
				s1_valid_q <= 1'b1;
			end else if (push_ready) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= x;
			y_s1 <= y;
			b_s1 <= pix_b;
			g_s1 <= pix_g;
			r_s1 <= pix_r;
			sb_s1 <= sum_b;
			sg_s1 <= sum_g;
			sr_s1 <= sum_r;
			odd_s1 <= y[0];
			emit_s1 <= pair_done && (y[0] || last_row);
			edge_s1 <= edge_pair;
		end
	end

	// vertical sum: stored even row on odd rows, the row doubled on a lone last row
	always_comb begin
		if (odd_s1) begin
			quad_b = {1'b0, sb_s1} + {1'b0, line_rd_s1[SW-1:0]};
			quad_g = {1'b0, sg_s1} + {1'b0, line_rd_s1[2*SW-1:SW]};
			quad_r = {1'b0, sr_s1} + {1'b0, line_rd_s1[3*SW-1:2*SW]};
		end else begin
			quad_b = {sb_s1, 1'b0};
			quad_g = {sg_s1, 1'b0};
			quad_r = {sr_s1, 1'b0};
		end
		quad_b_rnd = quad_b + (SW+1)'(2);
		quad_g_rnd = quad_g + (SW+1)'(2);
		quad_r_rnd = quad_r + (SW+1)'(2);
		luma_sum = 16'd66 * {8'd0, r_s1} + 16'd129 * {8'd0, g_s1}
			+ 16'd25 * {8'd0, b_s1} + 16'd128;
	end

	assign push_valid = s1_valid_q;

	always_comb begin
		push_entry.row = y_s1;
		push_entry.column = x_s1;
		push_entry.luma = luma_sum[15:8] + 8'd16;
		push_entry.chroma = emit_s1;
		push_entry.edge_pair = edge_s1;
		push_entry.avg_b = quad_b_rnd[SW:2];
		push_entry.avg_g = quad_g_rnd[SW:2];
		push_entry.avg_r = quad_r_rnd[SW:2];
	end

endmodule

`default_nettype wire

@@ rtl/bn12_back.sv @@
// back end: chroma conversion and the Y, U, V result sequencer
`default_nettype none

module bn12_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  pop_valid,
	output logic                       pop_ready,
	input  wire bn12_pkg::quad_entry_t pop_entry,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [31:0]                m_tdata,
	output logic                       m_tuser,
	output logic                       m_tlast
);

	localparam int PW = bn12_pkg::POS_W;

	bn12_pkg::step_t       step_q;
	bn12_pkg::step_t       step_d;
	logic                  cur_valid_q;
	logic                  cur_valid_d;
	bn12_pkg::quad_entry_t cur_q;
	logic [7:0]            u_q;
	logic [7:0]            v_q;

	logic                  cur_last;
	logic                  pop;
	logic                  plane;
	logic [PW-1:0]         out_row;
	logic [PW-1:0]         out_column;
	logic [7:0]            sample_value;

	logic signed [16:0]    ab_s;
	logic signed [16:0]    ag_s;
	logic signed [16:0]    ar_s;
	logic signed [16:0]    u_sum;
	logic signed [16:0]    v_sum;
	logic signed [16:0]    u_off;
	logic signed [16:0]    v_off;

	assign ab_s = $signed({9'd0, pop_entry.avg_b});
	assign ag_s = $signed({9'd0, pop_entry.avg_g});
	assign ar_s = $signed({9'd0, pop_entry.avg_r});
	assign u_sum = 17'sd128 - 17'sd38 * ar_s - 17'sd74 * ag_s + 17'sd112 * ab_s;
	assign v_sum = 17'sd128 + 17'sd112 * ar_s - 17'sd94 * ag_s - 17'sd18 * ab_s;
	assign u_off = (u_sum >>> 8) + 17'sd128;
	assign v_off = (v_sum >>> 8) + 17'sd128;

	// final word of this pixel: Y alone, Y+U at an odd edge, else Y+U+V
	always_comb begin
		case (step_q)
			bn12_pkg::STEP_Y: cur_last = !cur_q.chroma;
			bn12_pkg::STEP_U: cur_last = cur_q.edge_pair;
			default:          cur_last = 1'b1;
		endcase
	end

	assign pop_ready = !cur_valid_q || (m_tready && cur_last);
	assign pop = pop_valid && pop_ready;

	// next state
	always_comb begin
		step_d = step_q;
		cur_valid_d = cur_valid_q;
		if (pop) begin
			step_d = bn12_pkg::STEP_Y;
			cur_valid_d = 1'b1;
		end else if (cur_valid_q && m_tready) begin
			if (cur_last) begin
				cur_valid_d = 1'b0;
			end else if (step_q == bn12_pkg::STEP_Y) begin
				step_d = bn12_pkg::STEP_U;
			end else begin
				step_d = bn12_pkg::STEP_V;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= bn12_pkg::STEP_Y;
			cur_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			cur_valid_q <= cur_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_entry;
			u_q <= bn12_pkg::clamp_byte(u_off);
			v_q <= bn12_pkg::clamp_byte(v_off);
		end
	end

	// outputs
	always_comb begin
		case (step_q)
			bn12_pkg::STEP_U: begin
				plane = 1'b1;
				out_row = {1'b0, cur_q.row[PW-1:1]};
				out_column = {cur_q.column[PW-1:1], 1'b0};
				sample_value = u_q;
			end
			bn12_pkg::STEP_V: begin
				plane = 1'b1;
				out_row = {1'b0, cur_q.row[PW-1:1]};
				out_column = {cur_q.column[PW-1:1], 1'b1};
				sample_value = v_q;
			end
			default: begin
				plane = 1'b0;
				out_row = cur_q.row;
				out_column = cur_q.column;
				sample_value = cur_q.luma;
			end
		endcase
	end

	assign m_tvalid = cur_valid_q;
	assign m_tdata = {sample_value, out_column, out_row};
	assign m_tuser = plane;
	assign m_tlast = cur_last;

endmodule

`default_nettype wire

@@ rtl/bgra_to_nv12_converter.sv @@
// top level of the bgra to nv12 converter
`default_nettype none

// BGRA pixels in raster order go in, one word per pixel, and NV12 bytes
// (BT.601 limited range) come out: a luma byte for every pixel, then a U and
// a V byte on the pixel that completes a 2x2 quad (U only at the final column
// of an odd frame width). A new pixel can be taken every cycle while the queue
// has room; the result channel carries one byte per cycle while m_tready is
// high, so a pixel takes one result word on even rows and two or three on the
// pixel that closes a quad, about two per pixel on odd rows. A four-word queue
// between the front end and the result sequencer absorbs the burst. A pixel
// is registered in the front end's stage 1, a queue slot and the result
// sequencer before its first result word can be taken. The even row's pair
// sums sit in a 2048 x 27 line store that needs no clearing after reset.
// frame_width and frame_height should only be written while the block is idle.
module bgra_to_nv12_converter (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [bn12_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [23:0]                s_tdata,   // blue, green, red
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [31:0]                     m_tdata,   // out_row, out_column, sample_value
	output logic                            m_tuser,   // plane
	output logic                            m_tlast
);

	logic                  push_valid;
	logic                  push_ready;
	bn12_pkg::quad_entry_t push_entry;
	logic                  pop_valid;
	logic                  pop_ready;
	bn12_pkg::quad_entry_t pop_entry;

	bn12_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	bn12_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	bn12_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

@@ rtl/bn12_checker.sv @@
// port-level checks for the bgra to nv12 converter
`default_nettype none

module bn12_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);

	// a stalled word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
	else $error("stalled output word changed");

	// limited-range luma
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:24] >= 8'd16 && m_tdata[31:24] <= 8'd235)
	else $error("luma byte out of limited range");

	// a V byte always closes its pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tdata[12] |-> m_tlast)
	else $error("V byte without last");

	// a U byte that does not close its pixel is followed straight by its V byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser && !m_tdata[12] && !m_tlast
			|=> m_tvalid && m_tuser && m_tdata[12])
	else $error("U byte not followed by V byte");

endmodule

bind bgra_to_nv12_converter bn12_checker u_bn12_checker (.*);

`default_nettype wire
